// ===== rtl/bmpd_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpd_pkg
// shared types and codes for the bmp pixel stream decoder
// ----------------------------------------------------------------------------
package bmpd_pkg;

  localparam int QUEUE_DEPTH = 4;

  // result kinds
  localparam logic [2:0] KIND_PIXEL      = 3'd0;
  localparam logic [2:0] KIND_HEADER     = 3'd1;
  localparam logic [2:0] KIND_NOT_BMP    = 3'd2;
  localparam logic [2:0] KIND_BAD_DEPTH  = 3'd3;
  localparam logic [2:0] KIND_COMPRESSED = 3'd4;
  localparam logic [2:0] KIND_BAD_OFFSET = 3'd5;

  // work codes between front and back
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_PIXEL  = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [15:0] bit_depth;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [1:0]  slot;
    logic [1:0]  top;
    logic        last;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] depth;
  } tok_t;

endpackage

// ===== rtl/bmpd_front.sv =====
// ----------------------------------------------------------------------------
// bmpd_front
// byte parser: header capture, checks, row walk; issues work tokens
// ----------------------------------------------------------------------------
module bmpd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  bmpd_pkg::in_item_t item,
  output logic               tok_push,
  output bmpd_pkg::tok_t     tok
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_PIXELS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [31:0] POS_SIG0    = 32'd0;
  localparam logic [31:0] POS_SIG1    = 32'd1;
  localparam logic [31:0] POS_OFFSET  = 32'd10;
  localparam logic [31:0] POS_WIDTH   = 32'd18;
  localparam logic [31:0] POS_HEIGHT  = 32'd22;
  localparam logic [31:0] POS_DEPTH   = 32'd28;
  localparam logic [31:0] POS_COMPR   = 32'd30;
  localparam logic [31:0] POS_HDR_END = 32'd33;
  localparam logic [31:0] MIN_OFFSET  = 32'd46;
  localparam logic [7:0]  SIG_B       = 8'd66;
  localparam logic [7:0]  SIG_M       = 8'd77;
  localparam logic [31:0] POS_MAX     = '1;

  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [7:0]  sig0_r, sig0_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [15:0] depth_r, depth_nxt;
  logic [31:0] compr_r, compr_nxt;
  logic [47:0] stride_r, stride_nxt;
  logic [31:0] row_cnt_r, row_cnt_nxt;
  logic [47:0] rbc_r, rbc_nxt;
  logic [12:0] idx_r, idx_nxt;
  logic [47:0] start_r, start_nxt;
  logic [47:0] prod_r;
  logic [47:0] used_r;

  logic [1:0]  phase_cur;
  logic [31:0] pos_cur;
  logic [7:0]  b;
  logic [12:0] bpp;
  logic [12:0] top;
  logic        in_row;
  logic        is_top;
  logic [47:0] rbc_inc;
  logic        row_end;
  logic        last_pix;
  logic [13:0] idx_inc;
  logic        idx_wrap;
  logic [32:0] row_cnt_inc;
  logic [48:0] round_sum;
  logic [31:0] compr_all;
  logic        pix_run;

  assign phase_cur   = item.first ? PH_HEADER : phase_r;
  assign pos_cur     = item.first ? POS_SIG0 : pos_r;
  assign b           = item.data_byte;
  assign bpp         = depth_r[15:3];
  assign top         = (bpp < 13'd4) ? (bpp - 13'd1) : 13'd3;
  assign in_row      = rbc_r < used_r;
  assign is_top      = idx_r == top;
  assign rbc_inc     = rbc_r + 48'd1;
  assign row_end     = rbc_inc >= stride_r;
  assign last_pix    = is_top && ((start_r + 48'(bpp)) == used_r) &&
                       (row_cnt_r == (height_r - 32'd1));
  assign idx_inc     = {1'b0, idx_r} + 14'd1;
  assign idx_wrap    = idx_inc >= {1'b0, bpp};
  assign row_cnt_inc = {1'b0, row_cnt_r} + 33'd1;
  assign round_sum   = {1'b0, prod_r} + 49'd31;
  assign compr_all   = {b, compr_r[23:0]};
  assign pix_run     = take && ((phase_cur == PH_PIXELS) ||
                       ((phase_cur == PH_SKIP) && (pos_cur == offset_r)));

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    sig0_nxt    = sig0_r;
    offset_nxt  = offset_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    depth_nxt   = depth_r;
    compr_nxt   = compr_r;
    stride_nxt  = stride_r;
    row_cnt_nxt = row_cnt_r;
    rbc_nxt     = rbc_r;
    idx_nxt     = idx_r;
    start_nxt   = start_r;
    tok_push    = 1'b0;
    tok         = '0;
    if (take) begin
      phase_nxt = phase_cur;
      pos_nxt   = pos_cur;
      case (phase_cur)
        PH_HEADER: begin
          if (pos_cur == POS_SIG0) begin
            sig0_nxt = b;
          end
          if (pos_cur >= POS_OFFSET && pos_cur < POS_OFFSET + 32'd4) begin
            offset_nxt[8*(2'(pos_cur - POS_OFFSET)) +: 8] = b;
          end
          if (pos_cur >= POS_WIDTH && pos_cur < POS_WIDTH + 32'd4) begin
            width_nxt[8*(2'(pos_cur - POS_WIDTH)) +: 8] = b;
          end
          if (pos_cur >= POS_HEIGHT && pos_cur < POS_HEIGHT + 32'd4) begin
            height_nxt[8*(2'(pos_cur - POS_HEIGHT)) +: 8] = b;
          end
          if (pos_cur == POS_DEPTH) begin
            depth_nxt[7:0] = b;
          end
          if (pos_cur == POS_DEPTH + 32'd1) begin
            depth_nxt[15:8] = b;
          end
          if (pos_cur >= POS_COMPR && pos_cur < POS_COMPR + 32'd4) begin
            compr_nxt[8*(2'(pos_cur - POS_COMPR)) +: 8] = b;
          end
          if (pos_cur != POS_MAX) begin
            pos_nxt = pos_cur + 32'd1;
          end
          if (pos_cur == POS_SIG1 && (sig0_r != SIG_B || b != SIG_M)) begin
            tok_push  = 1'b1;
            tok.op    = bmpd_pkg::OP_REPORT;
            tok.kind  = bmpd_pkg::KIND_NOT_BMP;
            phase_nxt = PH_DONE;
            pos_nxt   = pos_cur;
          end else if (pos_cur == POS_HDR_END) begin
            tok_push  = 1'b1;
            tok.op    = bmpd_pkg::OP_REPORT;
            phase_nxt = PH_DONE;
            if (bpp == 13'd0) begin
              tok.kind = bmpd_pkg::KIND_BAD_DEPTH;
            end else if (compr_all != 32'd0) begin
              tok.kind = bmpd_pkg::KIND_COMPRESSED;
            end else if (offset_r < MIN_OFFSET) begin
              tok.kind = bmpd_pkg::KIND_BAD_OFFSET;
            end else begin
              tok.kind    = bmpd_pkg::KIND_HEADER;
              tok.width   = width_r;
              tok.height  = height_r;
              tok.depth   = depth_r;
              stride_nxt  = 48'({round_sum[48:5], 2'b00});
              row_cnt_nxt = '0;
              rbc_nxt     = '0;
              idx_nxt     = '0;
              start_nxt   = '0;
              if (width_r != 32'd0 && height_r != 32'd0) begin
                phase_nxt = PH_SKIP;
              end
            end
          end
        end
        PH_SKIP: begin
          if (pos_cur == offset_r) begin
            phase_nxt = PH_PIXELS;
          end else if (pos_cur != POS_MAX) begin
            pos_nxt = pos_cur + 32'd1;
          end
        end
        default: begin
        end
      endcase
      if (pix_run) begin
        if (in_row) begin
          if (idx_r < 13'd3 || is_top) begin
            tok_push = 1'b1;
            tok.op   = is_top ? bmpd_pkg::OP_PIXEL : bmpd_pkg::OP_HOLD;
            tok.kind = bmpd_pkg::KIND_PIXEL;
            tok.data = b;
            tok.slot = idx_r[1:0];
            tok.top  = top[1:0];
            tok.last = last_pix;
          end
          if (!last_pix) begin
            idx_nxt = idx_wrap ? 13'd0 : idx_inc[12:0];
            if (idx_wrap) begin
              start_nxt = rbc_inc;
            end
          end
        end
        if (in_row && last_pix) begin
          phase_nxt = PH_DONE;
        end else begin
          rbc_nxt = rbc_inc;
          if (row_end) begin
            rbc_nxt     = '0;
            idx_nxt     = '0;
            start_nxt   = '0;
            row_cnt_nxt = row_cnt_inc[31:0];
            if (row_cnt_inc >= {1'b0, height_r}) begin
              phase_nxt = PH_DONE;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      pos_r     <= '0;
      sig0_r    <= '0;
      offset_r  <= '0;
      width_r   <= '0;
      height_r  <= '0;
      depth_r   <= '0;
      compr_r   <= '0;
      stride_r  <= '0;
      row_cnt_r <= '0;
      rbc_r     <= '0;
      idx_r     <= '0;
      start_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      sig0_r    <= sig0_nxt;
      offset_r  <= offset_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      depth_r   <= depth_nxt;
      compr_r   <= compr_nxt;
      stride_r  <= stride_nxt;
      row_cnt_r <= row_cnt_nxt;
      rbc_r     <= rbc_nxt;
      idx_r     <= idx_nxt;
      start_r   <= start_nxt;
    end
  end

  // products settle long before the header end and the first pixel byte
  always_ff @(posedge clk) begin
    prod_r <= 48'(depth_r) * 48'(width_r);
    used_r <= 48'(45'(width_r) * 45'(bpp));
  end

  a_report_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_push && tok.op == bmpd_pkg::OP_REPORT) |->
      (pos_cur == POS_SIG1 || pos_cur == POS_HDR_END))
    else $error("report token away from signature or header end");

  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !item.first && phase_r == PH_DONE) |-> !tok_push)
    else $error("token issued after parse finished");

endmodule

// ===== rtl/bmpd_fifo.sv =====
// ----------------------------------------------------------------------------
// bmpd_fifo
// short token queue between parser and pixel assembler
// ----------------------------------------------------------------------------
module bmpd_fifo #(
  parameter int DEPTH = bmpd_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bmpd_pkg::tok_t push_tok,
  output logic           full,
  input  logic           pop,
  output bmpd_pkg::tok_t pop_tok,
  output logic           empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bmpd_pkg::tok_t mem_r [DEPTH];
  logic [PW-1:0]  wptr_r, wptr_nxt;
  logic [PW-1:0]  rptr_r, rptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full    = count_r == CW'(DEPTH);
  assign empty   = count_r == '0;
  assign pop_tok = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_tok;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + CW'(1))
    else $error("queue count did not follow push");

endmodule

// ===== rtl/bmpd_back.sv =====
// ----------------------------------------------------------------------------
// bmpd_back
// pixel assembler: holds channel bytes, builds rgba and report items
// ----------------------------------------------------------------------------
module bmpd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tok_valid,
  input  bmpd_pkg::tok_t      tok,
  output logic                tok_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output bmpd_pkg::out_item_t out_item
);

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  logic                out_valid_r, out_valid_nxt;
  bmpd_pkg::out_item_t out_item_r;
  bmpd_pkg::out_item_t res;
  logic [7:0]          held0_r, held1_r, held2_r;
  logic                needs_out;
  logic                taken;

  assign needs_out = tok.op != bmpd_pkg::OP_HOLD;
  assign taken     = out_pop && out_valid_r;
  assign tok_pop   = tok_valid && (!needs_out || !out_valid_r || taken);
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    res = '0;
    res.kind = tok.kind;
    if (tok.op == bmpd_pkg::OP_PIXEL) begin
      res.blue  = (tok.top == 2'd0) ? tok.data : held0_r;
      res.green = (tok.top <= 2'd1) ? tok.data : held1_r;
      res.red   = (tok.top <= 2'd2) ? tok.data : held2_r;
      res.alpha = (tok.top == 2'd3) ? tok.data : ALPHA_OPAQUE;
      res.last  = tok.last;
    end else begin
      res.image_width  = tok.width;
      res.image_height = tok.height;
      res.bit_depth    = tok.depth;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (taken) begin
      out_valid_nxt = 1'b0;
    end
    if (tok_pop && needs_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop && needs_out) begin
      out_item_r <= res;
    end
    if (tok_pop) begin
      case (tok.slot)
        2'd0: held0_r <= tok.data;
        2'd1: held1_r <= tok.data;
        2'd2: held2_r <= tok.data;
        default: begin
        end
      endcase
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_pop && needs_out) |-> (!out_valid_r || taken))
    else $error("result item overwritten before it was taken");

endmodule

// ===== rtl/bmp_pixel_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// bmp_pixel_stream_decoder_top
// bmp (uncompressed) byte stream to rgba pixel decoder
// ----------------------------------------------------------------------------
// input channel: push/full, one file byte per item; first marks byte 0 of a
// new file and restarts the parse (items already queued still come out)
// result channel: empty/pop; the oldest result sits on out_item while empty
// is low. kinds: pixel, header, or one of the errors (not bmp, bad depth,
// compressed, bad offset)
// header and errors come out after byte 33 (not bmp after byte 1); pixels
// follow from the pixel offset, one per pixel, rows in file order, padding
// dropped, last on the final pixel
// results pass through the token queue and the result register
// throughput: one byte per cycle while the queue is not full, set by the
// parser's single byte path
// a token queue between parser and assembler absorbs stalls; a stalled
// result holds and the parser keeps taking bytes until the queue fills
// reset (rst_n low, synchronous): parse back to header, queue and result
// register emptied
// ----------------------------------------------------------------------------
module bmp_pixel_stream_decoder_top #(
  parameter int QUEUE_DEPTH = bmpd_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  bmpd_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output bmpd_pkg::out_item_t out_item
);

  logic           take;
  logic           q_push;
  bmpd_pkg::tok_t q_in;
  logic           q_full;
  logic           q_pop;
  bmpd_pkg::tok_t q_out;
  logic           q_empty;

  assign in_full = q_full;
  assign take    = in_push && !q_full;

  bmpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .item     (in_item),
    .tok_push (q_push),
    .tok      (q_in)
  );

  bmpd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tok (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_tok  (q_out),
    .empty    (q_empty)
  );

  bmpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (!q_empty),
    .tok       (q_out),
    .tok_pop   (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bmp pixel stream decoder testbench
// streams bmp files byte by byte into the decoder and predicts every header,
// error and rgba pixel result in lockstep; results are checked in order as
// they are popped, under random idling on both sides and a long output stall
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int LONG_HOLD    = 150;
  localparam int RANDOM_ITEMS = 280;
  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;

  typedef enum logic [1:0] {PH_HEADER, PH_SKIP, PH_PIXELS, PH_DONE} parse_phase_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic                in_full;
  bmpd_pkg::in_item_t  in_item = '0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  bmpd_pkg::out_item_t out_item;

  bmp_pixel_stream_decoder_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  // decoder model state
  logic [31:0]  dec_pos;
  logic [31:0]  dec_offset;
  logic [31:0]  dec_width;
  logic [31:0]  dec_height;
  logic [15:0]  dec_depth;
  logic [31:0]  dec_comp;
  logic [63:0]  dec_stride;
  logic [31:0]  dec_rows;
  logic [63:0]  dec_row_bytes;
  logic [31:0]  dec_pix_idx;
  logic [7:0]   dec_held [3];
  parse_phase_t dec_phase;

  bmpd_pkg::out_item_t pending_results[$];
  logic [7:0]          file_bytes[$];
  int                  mismatch_count = 0;
  int                  bytes_sent = 0;
  int                  cycle_count = 0;
  int                  send_idle_pct = 0;
  int                  stall_pct = 0;
  int                  hold_gen = 0;
  int                  hold_seen = 0;
  int                  hold_left = 0;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void restart_parse();
    dec_pos = '0;
    dec_offset = '0;
    dec_width = '0;
    dec_height = '0;
    dec_depth = '0;
    dec_comp = '0;
    dec_stride = '0;
    dec_rows = '0;
    dec_row_bytes = '0;
    dec_pix_idx = '0;
    dec_held[0] = '0;
    dec_held[1] = '0;
    dec_held[2] = '0;
    dec_phase = PH_HEADER;
  endfunction

  function automatic void header_step(input logic [7:0] b, inout bmpd_pkg::out_item_t r,
                                      inout logic hit);
    logic [31:0] p;
    p = dec_pos;
    if (p == 0) dec_held[0] = b;
    if (p == 1 && (dec_held[0] != SIG_B || b != SIG_M)) begin
      r.kind = bmpd_pkg::KIND_NOT_BMP;
      hit = 1'b1;
      dec_phase = PH_DONE;
      return;
    end
    if (p >= 10 && p < 14) dec_offset[8*(p-10) +: 8] = b;
    if (p >= 18 && p < 22) dec_width[8*(p-18) +: 8] = b;
    if (p >= 22 && p < 26) dec_height[8*(p-22) +: 8] = b;
    if (p == 28) dec_depth[7:0] = b;
    if (p == 29) dec_depth[15:8] = b;
    if (p >= 30 && p < 34) dec_comp[8*(p-30) +: 8] = b;
    if (p == 33) begin
      hit = 1'b1;
      dec_phase = PH_DONE;
      if (dec_depth[15:3] == 0) begin
        r.kind = bmpd_pkg::KIND_BAD_DEPTH;
      end else if (dec_comp != 0) begin
        r.kind = bmpd_pkg::KIND_COMPRESSED;
      end else if (dec_offset < 46) begin
        r.kind = bmpd_pkg::KIND_BAD_OFFSET;
      end else begin
        r.kind = bmpd_pkg::KIND_HEADER;
        r.image_width = dec_width;
        r.image_height = dec_height;
        r.bit_depth = dec_depth;
        dec_stride = ((64'(dec_depth) * 64'(dec_width) + 64'd31) >> 5) * 64'd4;
        if (dec_width != 0 && dec_height != 0) dec_phase = PH_SKIP;
      end
    end
    if (dec_pos != 32'hFFFF_FFFF) dec_pos = dec_pos + 1;
  endfunction

  function automatic void pixel_step(input logic [7:0] b, inout bmpd_pkg::out_item_t r,
                                     inout logic hit);
    logic [12:0] bpp;
    logic [63:0] used;
    logic [63:0] start;
    logic [31:0] idx;
    logic [31:0] top;
    bpp = dec_depth[15:3];
    used = 64'(dec_width) * 64'(bpp);
    if (dec_row_bytes < used) begin
      idx = dec_pix_idx;
      top = (bpp < 4) ? 32'(bpp) - 1 : 32'd3;
      if (idx < 3) dec_held[idx[1:0]] = b;
      if (idx == top) begin
        r.kind = bmpd_pkg::KIND_PIXEL;
        r.blue = dec_held[0];
        r.green = (bpp > 1) ? dec_held[1] : dec_held[0];
        r.red = (bpp > 2) ? dec_held[2] : r.green;
        r.alpha = (bpp > 3) ? b : 8'hFF;
        hit = 1'b1;
        start = dec_row_bytes - 64'(idx);
        if (start + 64'(bpp) == used && dec_rows == dec_height - 1) begin
          r.last = 1'b1;
          dec_phase = PH_DONE;
          return;
        end
      end
      idx = idx + 1;
      dec_pix_idx = (idx >= 32'(bpp)) ? 32'd0 : (idx & 32'h1FFF);
    end
    dec_row_bytes = dec_row_bytes + 1;
    if (dec_row_bytes >= dec_stride) begin
      dec_row_bytes = '0;
      dec_pix_idx = '0;
      dec_rows = dec_rows + 1;
      if (dec_rows >= dec_height) dec_phase = PH_DONE;
    end
  endfunction

  function automatic void decode_byte(input bmpd_pkg::in_item_t it);
    bmpd_pkg::out_item_t r;
    logic                hit;
    r = '0;
    hit = 1'b0;
    if (it.first) restart_parse();
    case (dec_phase)
      PH_HEADER: header_step(it.data_byte, r, hit);
      PH_SKIP: begin
        if (dec_pos == dec_offset) begin
          dec_phase = PH_PIXELS;
          pixel_step(it.data_byte, r, hit);
        end else if (dec_pos != 32'hFFFF_FFFF) begin
          dec_pos = dec_pos + 1;
        end
      end
      PH_PIXELS: pixel_step(it.data_byte, r, hit);
      default: ;
    endcase
    if (hit) pending_results = {pending_results, r};
  endfunction

  // result side: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_seen != hold_gen) begin
      hold_seen <= hold_gen;
      hold_left <= LONG_HOLD;
      out_pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    bmpd_pkg::out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10)
          $display("unexpected result: kind=%0d rgba=%02x%02x%02x%02x last=%0b",
                   out_item.kind, out_item.red, out_item.green, out_item.blue,
                   out_item.alpha, out_item.last);
      end else begin
        want = pending_results.pop_front();
        if (out_item.kind !== want.kind || out_item.red !== want.red ||
            out_item.green !== want.green || out_item.blue !== want.blue ||
            out_item.alpha !== want.alpha || out_item.image_width !== want.image_width ||
            out_item.image_height !== want.image_height ||
            out_item.bit_depth !== want.bit_depth || out_item.last !== want.last) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10) begin
            $display("mismatch at cycle %0d", cycle_count);
            $display("  expected kind=%0d rgba=%02x%02x%02x%02x w=%0d h=%0d d=%0d last=%0b",
                     want.kind, want.red, want.green, want.blue, want.alpha,
                     want.image_width, want.image_height, want.bit_depth, want.last);
            $display("  actual   kind=%0d rgba=%02x%02x%02x%02x w=%0d h=%0d d=%0d last=%0b",
                     out_item.kind, out_item.red, out_item.green, out_item.blue,
                     out_item.alpha, out_item.image_width, out_item.image_height,
                     out_item.bit_depth, out_item.last);
          end
        end
      end
    end
  end

  task automatic send_item(input bmpd_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    decode_byte(it);
    bytes_sent = bytes_sent + 1;
  endtask

  task automatic wait_all_results();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // header fields little-endian; pixel data only when the header can be valid
  function automatic void build_file(input logic [31:0] w, input logic [31:0] h,
                                     input logic [15:0] d, input logic [31:0] off,
                                     input logic [31:0] comp, input logic [7:0] s0,
                                     input logic [7:0] s1);
    logic [63:0] stride;
    logic [63:0] body;
    int i;
    file_bytes.delete();
    for (i = 0; i < 34; i++) file_bytes = {file_bytes, 8'($urandom)};
    file_bytes[0] = s0;
    file_bytes[1] = s1;
    for (i = 0; i < 4; i++) begin
      file_bytes[10+i] = off[8*i +: 8];
      file_bytes[18+i] = w[8*i +: 8];
      file_bytes[22+i] = h[8*i +: 8];
      file_bytes[30+i] = comp[8*i +: 8];
    end
    file_bytes[28] = d[7:0];
    file_bytes[29] = d[15:8];
    stride = ((64'(d) * 64'(w) + 64'd31) >> 5) * 64'd4;
    body = stride * 64'(h);
    if (s0 == SIG_B && s1 == SIG_M && d[15:3] != 0 && comp == 0 && off >= 46 &&
        off < 256 && w != 0 && h != 0 && w <= 64 && h <= 64 && body <= 4096) begin
      while (file_bytes.size() < off) file_bytes = {file_bytes, 8'($urandom)};
      for (i = 0; i < body; i++) file_bytes = {file_bytes, 8'($urandom)};
    end
    repeat ($urandom_range(0, 4)) file_bytes = {file_bytes, 8'($urandom)};
  endfunction

  task automatic send_file(input int keep);
    bmpd_pkg::in_item_t it;
    int i;
    for (i = 0; i < keep && i < file_bytes.size(); i++) begin
      it.data_byte = file_bytes[i];
      it.first = (i == 0);
      send_item(it);
    end
  endtask

  task automatic send_bmp(input logic [31:0] w, input logic [31:0] h,
                          input logic [15:0] d, input logic [31:0] off,
                          input logic [31:0] comp);
    build_file(w, h, d, off, comp, SIG_B, SIG_M);
    send_file(file_bytes.size());
  endtask

  task automatic test_header_errors();
    build_file(2, 2, 24, 54, 0, SIG_B, 8'h00);
    send_file(file_bytes.size());
    build_file(2, 2, 24, 54, 0, 8'hBD, SIG_M);
    send_file(file_bytes.size());
    build_file(2, 2, 0, 0, 32'hFFFF_FFFF, 8'h00, 8'hFF);
    send_file(file_bytes.size());
    send_bmp(2, 2, 0, 54, 32'hFFFF_FFFF);
    send_bmp(2, 2, 7, 54, 0);
    send_bmp(2, 2, 16'hFFFF, 32'hFFFF_FFFF, 1);
    send_bmp(2, 2, 24, 45, 0);
    send_bmp(2, 2, 24, 0, 0);
  endtask

  task automatic test_empty_images();
    send_bmp(0, 32'hFFFF_FFFF, 24, 54, 0);
    send_bmp(32'hFFFF_FFFF, 0, 16'hFFFF, 32'hFFFF_FFFF, 0);
  endtask

  task automatic test_pixel_depths();
    send_bmp(1, 1, 8, 46, 0);
    send_bmp(3, 2, 8, 54, 0);
    send_bmp(3, 2, 12, 50, 0);
    send_bmp(3, 2, 16, 54, 0);
    send_bmp(3, 2, 24, 54, 0);
    send_bmp(3, 2, 32, 54, 0);
    send_bmp(2, 2, 48, 60, 0);
  endtask

  task automatic test_restart();
    build_file(2, 2, 24, 54, 0, SIG_B, SIG_M);
    send_file(40);
    build_file(2, 2, 24, 54, 0, SIG_B, SIG_M);
    send_file(60);
    send_bmp(2, 3, 24, 54, 0);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_gen = hold_gen + 1;
    send_bmp(6, 4, 8, 46, 0);
    send_bmp(4, 3, 24, 54, 0);
    wait_all_results();
  endtask

  task automatic send_random_file();
    logic [31:0] w;
    logic [31:0] h;
    logic [15:0] d;
    logic [31:0] off;
    logic [31:0] comp;
    logic [7:0]  s0;
    logic [7:0]  s1;
    int          roll;
    int          keep;
    w = $urandom_range(1, 6);
    h = $urandom_range(1, 4);
    off = $urandom_range(46, 72);
    comp = 0;
    s0 = SIG_B;
    s1 = SIG_M;
    case ($urandom_range(9))
      0, 1:    d = 8;
      2:       d = 16;
      3, 4:    d = 24;
      5, 6:    d = 32;
      7:       d = $urandom_range(8, 15);
      8: begin
        d = $urandom_range(40, 64);
        w = $urandom_range(1, 3);
      end
      default: d = $urandom_range(17, 31);
    endcase
    roll = $urandom_range(99);
    if (roll >= 96) begin
      w = $urandom;
      h = $urandom;
      d = $urandom;
      off = $urandom;
      comp = $urandom;
      if ($urandom_range(1)) begin
        s0 = $urandom;
        s1 = $urandom;
      end
    end else if (roll >= 92) begin
      if ($urandom_range(1)) begin
        w = 0;
        h = $urandom;
      end else begin
        h = 0;
        w = $urandom;
      end
    end else if (roll >= 88) begin
      off = $urandom_range(0, 45);
    end else if (roll >= 84) begin
      comp = $urandom;
    end else if (roll >= 80) begin
      d = $urandom_range(0, 7);
    end else if (roll >= 75) begin
      s0 = $urandom;
      s1 = $urandom;
    end
    build_file(w, h, d, off, comp, s0, s1);
    keep = file_bytes.size();
    if ($urandom_range(99) < 8) keep = $urandom_range(1, keep - 1);
    send_file(keep);
  endtask

  task automatic test_random_stream();
    int ph;
    int target;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 59; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 59; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      target = bytes_sent + RANDOM_ITEMS / 4;
      while (bytes_sent < target) send_random_file();
      wait_all_results();
    end
  endtask

  initial begin
    restart_parse();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_header_errors();
    test_empty_images();
    test_pixel_depths();
    test_restart();
    wait_all_results();
    test_backpressure();
    test_random_stream();
    wait_all_results();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bmpd_pkg.sv
rtl/bmpd_front.sv
rtl/bmpd_fifo.sv
rtl/bmpd_back.sv
rtl/bmp_pixel_stream_decoder_top.sv
verif/testbench.sv
